// ===== rtl/spa_pkg.sv =====
// Package for the sparse polynomial adder: command, status and sequencer codes.
// Depends on nothing; used by spa_front, spa_back and sparse_polynomial_adder_top.
package spa_pkg;

	localparam int MAX_TERMS_DEF = 32;
	localparam int EXP_BITS_DEF  = 8;

	localparam logic [1:0] FN_INS_A = 2'd0;
	localparam logic [1:0] FN_INS_B = 2'd1;
	localparam logic [1:0] FN_ADD   = 2'd2;

	localparam logic [1:0] RS_TERM  = 2'd0;
	localparam logic [1:0] RS_ACK   = 2'd1;
	localparam logic [1:0] RS_FULL  = 2'd2;
	localparam logic [1:0] RS_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		OP_INS_A,
		OP_INS_B,
		OP_ADD
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] coeff;
		logic [7:0]         exponent;
	} cmd_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_START,
		SQ_SCAN,
		SQ_EMIT
	} seq_t;

endpackage

// ===== rtl/spa_front.sv =====
// Front end: accepts command beats, decodes func and drops unused codes,
// and holds decoded commands in a two-entry queue. Depends on spa_pkg.
module spa_front import spa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] coeff,
	input  logic [7:0]         exponent,
	output logic               q_valid,
	output cmd_t               q_cmd,
	input  logic               q_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       take;
	logic       push;
	cmd_t       dec;

	assign cmd_stall = (cnt_q == 2'd2);
	assign take      = cmd_valid && !cmd_stall;

	always_comb begin
		dec.coeff    = coeff;
		dec.exponent = exponent;
		push         = take;
		unique case (func)
			FN_INS_A: dec.op = OP_INS_A;
			FN_INS_B: dec.op = OP_INS_B;
			FN_ADD:   dec.op = OP_ADD;
			default: begin
				dec.op = OP_ADD;
				push   = 1'b0;
			end
		endcase
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ===== rtl/spa_back.sv =====
// Back end: the two sorted term lists as cell chains, the merge sequencer
// and the result register. Depends on spa_pkg.
module spa_back import spa_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF,
	parameter int EXP_BITS  = EXP_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [32:0] sum_coeff,
	output logic [7:0]         out_exponent,
	output logic [1:0]         status,
	output logic               last
);

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TERMS);

	logic signed [31:0]  a_c_q [MAX_TERMS];
	logic [EXP_BITS-1:0] a_e_q [MAX_TERMS];
	logic signed [31:0]  b_c_q [MAX_TERMS];
	logic [EXP_BITS-1:0] b_e_q [MAX_TERMS];
	logic [CNT_W-1:0]    a_cnt_q, b_cnt_q;

	seq_t                st_q, st_d;
	logic [CNT_W-1:0]    ia_q, jb_q, ea_q, eb_q, ka_q, kb_q, k_q;
	logic [EXP_BITS-1:0] x_q;

	logic                res_valid_q;
	logic signed [32:0]  res_c_q;
	logic [7:0]          res_e_q;
	logic [1:0]          res_s_q;
	logic                res_l_q;

	logic                load_ok;
	logic [CNT_W-1:0]    ra, rb;
	logic signed [31:0]  a_rd_c, b_rd_c;
	logic [EXP_BITS-1:0] a_rd_e, b_rd_e, ins_e, x_d;
	logic                av, bv, hit_a, hit_b, lists_empty, a_full, b_full, run_done;
	logic                emit, e_last, ins_a, ins_b;
	logic signed [32:0]  e_coeff;
	logic [EXP_BITS-1:0] e_exp;
	logic [1:0]          e_stat;
	logic [MAX_TERMS-1:0] gt_a, gt_b;

	assign load_ok     = !res_valid_q || !res_stall;
	assign lists_empty = (a_cnt_q == '0) && (b_cnt_q == '0);
	assign a_full      = (a_cnt_q >= FULL_CNT);
	assign b_full      = (b_cnt_q >= FULL_CNT);
	assign ins_e       = EXP_BITS'(q_cmd.exponent);

	// read cursor per list
	always_comb begin
		unique case (st_q)
			SQ_SCAN: begin
				ra = ea_q;
				rb = eb_q;
			end
			SQ_EMIT: begin
				ra = ia_q + k_q - CNT_W'(1);
				rb = jb_q + k_q - CNT_W'(1);
			end
			default: begin
				ra = ia_q;
				rb = jb_q;
			end
		endcase
	end

	assign a_rd_c = a_c_q[ra[IDX_W-1:0]];
	assign a_rd_e = a_e_q[ra[IDX_W-1:0]];
	assign b_rd_c = b_c_q[rb[IDX_W-1:0]];
	assign b_rd_e = b_e_q[rb[IDX_W-1:0]];
	assign av     = ra < a_cnt_q;
	assign bv     = rb < b_cnt_q;
	assign hit_a  = (st_q == SQ_SCAN) && av && (a_rd_e == x_q);
	assign hit_b  = (st_q == SQ_SCAN) && bv && (b_rd_e == x_q);
	assign x_d    = (av && (!bv || a_rd_e >= b_rd_e)) ? a_rd_e : b_rd_e;
	assign run_done = (ea_q >= a_cnt_q) && (eb_q >= b_cnt_q);

	// sequencer outputs
	always_comb begin
		q_pop   = 1'b0;
		emit    = 1'b0;
		e_coeff = '0;
		e_exp   = '0;
		e_stat  = RS_TERM;
		e_last  = 1'b0;
		ins_a   = 1'b0;
		ins_b   = 1'b0;
		unique case (st_q)
			SQ_IDLE: begin
				if (q_valid && load_ok) begin
					q_pop = 1'b1;
					unique case (q_cmd.op)
						OP_INS_A: begin
							emit   = 1'b1;
							e_last = 1'b1;
							e_stat = a_full ? RS_FULL : RS_ACK;
							ins_a  = !a_full;
						end
						OP_INS_B: begin
							emit   = 1'b1;
							e_last = 1'b1;
							e_stat = b_full ? RS_FULL : RS_ACK;
							ins_b  = !b_full;
						end
						default: begin
							if (lists_empty) begin
								emit   = 1'b1;
								e_last = 1'b1;
								e_stat = RS_EMPTY;
							end
						end
					endcase
				end
			end
			SQ_EMIT: begin
				if (load_ok) begin
					emit    = 1'b1;
					e_exp   = x_q;
					e_coeff = ((k_q <= ka_q) ? 33'(a_rd_c) : 33'sd0)
						+ ((k_q <= kb_q) ? 33'(b_rd_c) : 33'sd0);
					e_last  = (k_q == CNT_W'(1)) && run_done;
				end
			end
			default: ;
		endcase
	end

	// sequencer next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			SQ_IDLE: begin
				if (q_valid && load_ok && q_cmd.op == OP_ADD && !lists_empty) begin
					st_d = SQ_START;
				end
			end
			SQ_START: st_d = SQ_SCAN;
			SQ_SCAN: begin
				if (!hit_a && !hit_b) begin
					st_d = SQ_EMIT;
				end
			end
			SQ_EMIT: begin
				if (load_ok && k_q == CNT_W'(1)) begin
					st_d = run_done ? SQ_IDLE : SQ_START;
				end
			end
			default: st_d = SQ_IDLE;
		endcase
	end

	// insert position: cells holding a larger exponent stay put
	always_comb begin
		for (int i = 0; i < MAX_TERMS; i++) begin
			gt_a[i] = (CNT_W'(i) < a_cnt_q) && (ins_e < a_e_q[i]);
			gt_b[i] = (CNT_W'(i) < b_cnt_q) && (ins_e < b_e_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TERMS; i++) begin
			if (ins_a && !gt_a[i]) begin
				if (i == 0 || gt_a[(i == 0) ? 0 : i - 1]) begin
					a_c_q[i] <= q_cmd.coeff;
					a_e_q[i] <= ins_e;
				end else begin
					a_c_q[i] <= a_c_q[(i == 0) ? 0 : i - 1];
					a_e_q[i] <= a_e_q[(i == 0) ? 0 : i - 1];
				end
			end
			if (ins_b && !gt_b[i]) begin
				if (i == 0 || gt_b[(i == 0) ? 0 : i - 1]) begin
					b_c_q[i] <= q_cmd.coeff;
					b_e_q[i] <= ins_e;
				end else begin
					b_c_q[i] <= b_c_q[(i == 0) ? 0 : i - 1];
					b_e_q[i] <= b_e_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
		if (emit) begin
			res_c_q <= e_coeff;
			res_e_q <= 8'(e_exp);
			res_s_q <= e_stat;
			res_l_q <= e_last;
		end
		if (st_q == SQ_START) begin
			x_q <= x_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= SQ_IDLE;
			a_cnt_q     <= '0;
			b_cnt_q     <= '0;
			ia_q        <= '0;
			jb_q        <= '0;
			ea_q        <= '0;
			eb_q        <= '0;
			ka_q        <= '0;
			kb_q        <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ins_a) begin
				a_cnt_q <= a_cnt_q + CNT_W'(1);
			end
			if (ins_b) begin
				b_cnt_q <= b_cnt_q + CNT_W'(1);
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				SQ_IDLE: begin
					ia_q <= '0;
					jb_q <= '0;
				end
				SQ_START: begin
					ea_q <= ia_q;
					eb_q <= jb_q;
				end
				SQ_SCAN: begin
					if (hit_a) begin
						ea_q <= ea_q + CNT_W'(1);
					end
					if (hit_b) begin
						eb_q <= eb_q + CNT_W'(1);
					end
					if (!hit_a && !hit_b) begin
						ka_q <= ea_q - ia_q;
						kb_q <= eb_q - jb_q;
						k_q  <= ((ea_q - ia_q) > (eb_q - jb_q)) ? (ea_q - ia_q) : (eb_q - jb_q);
					end
				end
				SQ_EMIT: begin
					if (emit) begin
						k_q <= k_q - CNT_W'(1);
						if (k_q == CNT_W'(1)) begin
							ia_q <= ea_q;
							jb_q <= eb_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign sum_coeff    = res_c_q;
	assign out_exponent = res_e_q;
	assign status       = res_s_q;
	assign last         = res_l_q;

endmodule

// ===== rtl/sparse_polynomial_adder_top.sv =====
// Top level of the sparse polynomial adder: front end, queue and back end.
// Depends on spa_pkg, spa_front and spa_back.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall, func, coeff, exponent): a beat with
//   func 0 or 1 inserts a term into list A or B, func 2 merges both lists and
//   streams the sum, func 3 is swallowed without a result.
//   Result channel (res_valid / res_stall, sum_coeff, out_exponent, status,
//   last): every insert gives one beat with status ack or full; an add gives
//   one beat per merged term, exponents descending, last set on the final one,
//   or a single empty-status beat when both lists are empty.
//   Flow: with the queue empty and the back end idle, a command is popped in
//   the cycle after its beat and its first result is loaded into the result
//   register at the edge that ends the pop cycle. An insert writes the cell
//   chain at that same edge, so inserts and empty adds run one per cycle while
//   the receiver does not stall. An add is popped, then for each exponent run
//   of result terms the sequencer passes through a start, a scan and an emit
//   state, following the single read cursor per list in the merge sequencer.
//   Reset clears both list counts, the queue and the sequencer; no sweep.
//   When the receiver stalls, the result register holds its beat, the back
//   end stops, the two-entry queue fills, and cmd_stall rises once it is full.
module sparse_polynomial_adder_top import spa_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF,
	parameter int EXP_BITS  = EXP_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] coeff,
	input  logic [7:0]         exponent,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [32:0] sum_coeff,
	output logic [7:0]         out_exponent,
	output logic [1:0]         status,
	output logic               last
);

	// queue between front and back
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	spa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.func      (func),
		.coeff     (coeff),
		.exponent  (exponent),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop)
	);

	spa_back #(
		.MAX_TERMS (MAX_TERMS),
		.EXP_BITS  (EXP_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.sum_coeff    (sum_coeff),
		.out_exponent (out_exponent),
		.status       (status),
		.last         (last)
	);

	// never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue popped while empty");

	// insert and empty results are single beats
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != RS_TERM) |-> last)
		else $error("status beat without last");

	// a status beat carries zero coefficient and exponent
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != RS_TERM) |-> (sum_coeff == '0 && out_exponent == '0))
		else $error("status beat with payload");

endmodule
